// File: hdl/hscs_pkg.sv
// Package for the connection handshake state controller.
// Holds state, kind and error codes and the result item types.
// No dependencies; used by all modules of the block.
`default_nettype none

package hscs_pkg;

   localparam logic [2:0] ST_STARTED     = 3'd0;
   localparam logic [2:0] ST_CLI_CRED    = 3'd1;
   localparam logic [2:0] ST_CLI_REG     = 3'd2;
   localparam logic [2:0] ST_CLI_TLS     = 3'd3;
   localparam logic [2:0] ST_SRV_CRED    = 3'd4;
   localparam logic [2:0] ST_SRV_TLS     = 3'd5;
   localparam logic [2:0] ST_SECURE      = 3'd6;
   localparam logic [2:0] ST_END         = 3'd7;

   localparam logic [1:0] KIND_NOTIFY    = 2'd0;
   localparam logic [1:0] KIND_SEND      = 2'd1;
   localparam logic [1:0] KIND_SELF      = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_HEADER     = 3'd1;
   localparam logic [2:0] ERR_FRAME      = 3'd2;
   localparam logic [2:0] ERR_ILLEGAL    = 3'd3;
   localparam logic [2:0] ERR_INVALID    = 3'd4;

   localparam logic       SRC_PEER       = 1'b0;
   localparam logic       SIDE_CLIENT    = 1'b0;

   localparam logic [1:0] SND_SELF       = 2'd0;
   localparam logic [1:0] SND_CERT       = 2'd1;

   localparam int         MAX_ITEMS      = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] state_value;
      logic [2:0] error_code;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [2:0]                   next_local;
      logic [3:0]                   next_peer;
      logic [1:0]                   count;
      item_type [MAX_ITEMS-1:0]     items;
   } decode_type;

endpackage

`default_nettype wire

// File: hdl/hscs_decode.sv
// Transition decoder of the connection handshake state controller.
// Checks one event against the stored states and builds up to three result items.
// Depends on hscs_pkg.
`default_nettype none

module hscs_decode
   import hscs_pkg::*;
(
   input  wire logic       side,
   input  wire logic [2:0] local_state,
   input  wire logic [3:0] peer_state,
   input  wire logic       source,
   input  wire logic       header_ok,
   input  wire logic       frame_ok,
   input  wire logic [3:0] requested_state,
   input  wire logic [1:0] sender,
   output decode_type      result
);

   logic       client;
   logic       by_cert;
   logic [2:0] err;
   logic       do_restart;
   logic       do_adv;
   logic       do_send;
   logic [2:0] adv_state;
   logic [3:0] peer_eff;
   logic [1:0] n;

   assign client  = (side == SIDE_CLIENT);
   assign by_cert = (sender == SND_CERT);

   always_comb begin
      err        = ERR_NONE;
      do_restart = 1'b0;
      do_adv     = 1'b0;
      do_send    = 1'b0;
      adv_state  = requested_state[2:0];
      peer_eff   = peer_state;
      if (source == SRC_PEER) begin
         if (!header_ok) begin
            err = ERR_HEADER;
         end else if (!frame_ok) begin
            err = ERR_FRAME;
         end else begin
            peer_eff = requested_state;
            if (requested_state[3]) begin
               err = ERR_INVALID;
            end else begin
               unique case (requested_state[2:0])
                  ST_STARTED: begin
                     do_restart = 1'b1;
                  end
                  ST_CLI_CRED: begin
                     if (local_state == ST_STARTED) do_adv = 1'b1;
                     else if (local_state != ST_CLI_CRED) err = ERR_ILLEGAL;
                  end
                  ST_CLI_REG: begin
                     if (client) begin
                        if (local_state == ST_CLI_CRED) do_adv = 1'b1;
                        else err = ERR_ILLEGAL;
                     end else if (local_state != ST_CLI_REG) begin
                        err = ERR_ILLEGAL;
                     end
                  end
                  ST_CLI_TLS: begin
                     if (client) begin
                        if (local_state == ST_CLI_CRED || local_state == ST_CLI_REG) begin
                           do_adv = 1'b1;
                        end else begin
                           err = ERR_ILLEGAL;
                        end
                     end else if (local_state != ST_CLI_TLS) begin
                        err = ERR_ILLEGAL;
                     end
                  end
                  ST_SRV_CRED: begin
                     if (client) begin
                        if (local_state == ST_CLI_TLS) do_adv = 1'b1;
                        else err = ERR_ILLEGAL;
                     end else if (local_state != ST_SRV_CRED) begin
                        err = ERR_ILLEGAL;
                     end
                  end
                  ST_SRV_TLS: begin
                     if (client) begin
                        if (local_state != ST_SRV_TLS) err = ERR_ILLEGAL;
                     end else if (local_state != ST_SRV_CRED) begin
                        err = ERR_ILLEGAL;
                     end else begin
                        do_adv = 1'b1;
                     end
                  end
                  ST_SECURE: begin
                     if (local_state != ST_SECURE) err = ERR_ILLEGAL;
                  end
                  ST_END: begin
                     do_adv = 1'b1;
                  end
                  default: begin
                     err = ERR_INVALID;
                  end
               endcase
            end
         end
      end else if (!requested_state[3]) begin
         do_send = 1'b1;
         unique case (requested_state[2:0])
            ST_STARTED:  do_restart = 1'b1;
            ST_CLI_CRED: do_adv = (local_state == ST_STARTED) && (sender == SND_SELF);
            ST_CLI_REG:  do_adv = (local_state == ST_CLI_CRED) && by_cert;
            ST_CLI_TLS:  do_adv = (local_state == ST_CLI_CRED || local_state == ST_CLI_REG)
                                  && by_cert;
            ST_SRV_CRED: do_adv = (local_state == ST_CLI_TLS) && by_cert;
            ST_SRV_TLS:  do_adv = (local_state == ST_SRV_CRED) && by_cert;
            ST_END:      do_adv = 1'b1;
            default:     do_adv = 1'b0;
         endcase
      end
   end

   always_comb begin
      result            = '0;
      result.next_local = local_state;
      result.next_peer  = peer_eff;
      n                 = 2'd0;
      if (err != ERR_NONE) begin
         result.items[n].kind       = KIND_ERROR;
         result.items[n].error_code = err;
         n = n + 2'd1;
      end else if (do_restart) begin
         if (local_state != ST_STARTED) begin
            result.next_local = ST_STARTED;
            result.items[n].kind        = KIND_NOTIFY;
            result.items[n].state_value = ST_STARTED;
            n = n + 2'd1;
            if (peer_eff != 4'd0) begin
               result.items[n].kind        = KIND_SEND;
               result.items[n].state_value = ST_STARTED;
               n = n + 2'd1;
            end
            result.items[n].kind        = KIND_SELF;
            result.items[n].state_value = ST_CLI_CRED;
            n = n + 2'd1;
         end else if (peer_eff == 4'd0) begin
            result.next_local = ST_CLI_CRED;
            result.items[n].kind        = KIND_NOTIFY;
            result.items[n].state_value = ST_CLI_CRED;
            n = n + 2'd1;
            result.items[n].kind        = KIND_SEND;
            result.items[n].state_value = ST_CLI_CRED;
            n = n + 2'd1;
         end
      end else if (do_adv) begin
         result.next_local = adv_state;
         result.items[n].kind        = KIND_NOTIFY;
         result.items[n].state_value = adv_state;
         n = n + 2'd1;
         if (do_send) begin
            result.items[n].kind        = KIND_SEND;
            result.items[n].state_value = adv_state;
            n = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         result.items[n - 2'd1].last = 1'b1;
      end
      result.count = n;
   end

endmodule

`default_nettype wire

// File: hdl/handshake_connection_state_fsm_core.sv
// An event is held in the input registers, then decoded into the result queue of
// three entries once the queue is empty or drains its last entry without a stall.
// Events with no result or one result go at one per cycle while the result channel
// does not stall; an event with more results holds the next one until one is left.
// Reset is synchronous and active high; it clears both states and the side to client.
`default_nettype none

module handshake_connection_state_fsm_core
   import hscs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic       csr_connection_side,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_source,
   input  wire logic       req_header_ok,
   input  wire logic       req_frame_ok,
   input  wire logic [3:0] req_requested_state,
   input  wire logic [1:0] req_sender,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_kind,
   output      logic [2:0] rsp_state_value,
   output      logic [2:0] rsp_error_code,
   output      logic       rsp_last
);

   logic       side_ff, side_in;
   logic [2:0] local_ff, local_in;
   logic [3:0] peer_ff, peer_in;
   logic       in_vld_ff, in_vld_in;
   logic       src_ff, hdr_ff, frm_ff;
   logic [3:0] rq_ff;
   logic [1:0] snd_ff;
   item_type [MAX_ITEMS-1:0] buf_ff, buf_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic       commit;
   logic       rsp_xfer;
   decode_type dec;

   hscs_decode u_decode (
      .side            (side_ff),
      .local_state     (local_ff),
      .peer_state      (peer_ff),
      .source          (src_ff),
      .header_ok       (hdr_ff),
      .frame_ok        (frm_ff),
      .requested_state (rq_ff),
      .sender          (snd_ff),
      .result          (dec)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign commit    = in_vld_ff && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && !rsp_stall));
   assign req_stall = in_vld_ff && !commit;
   assign accept    = req_valid && !req_stall;

   assign rsp_kind        = buf_ff[0].kind;
   assign rsp_state_value = buf_ff[0].state_value;
   assign rsp_error_code  = buf_ff[0].error_code;
   assign rsp_last        = buf_ff[0].last;

   always_comb begin
      side_in   = (csr_valid && csr_ready) ? csr_connection_side : side_ff;
      in_vld_in = accept ? 1'b1 : (commit ? 1'b0 : in_vld_ff);
      local_in  = commit ? dec.next_local : local_ff;
      peer_in   = commit ? dec.next_peer : peer_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      if (commit) begin
         buf_in = dec.items;
         cnt_in = dec.count;
      end else if (rsp_xfer) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= SIDE_CLIENT;
         local_ff  <= ST_STARTED;
         peer_ff   <= 4'd0;
         in_vld_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         side_ff   <= side_in;
         local_ff  <= local_in;
         peer_ff   <= peer_in;
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (accept) begin
         src_ff <= req_source;
         hdr_ff <= req_header_ok;
         frm_ff <= req_frame_ok;
         rq_ff  <= req_requested_state;
         snd_ff <= req_sender;
      end
   end

endmodule

`default_nettype wire

// File: hdl/hscs_checker.sv
// Port-level checker for the connection handshake state controller.
// Depends on hscs_pkg; bound to handshake_connection_state_fsm_core below.
`default_nettype none

module hscs_checker
   import hscs_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [2:0] rsp_state_value,
   input wire logic [2:0] rsp_error_code,
   input wire logic       rsp_last
);

   // An error is always the only result of its event.
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_last && rsp_error_code != ERR_NONE)
      else $error("error transfer is not a single item with a code");

   a_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == ERR_NONE)
      else $error("non-error transfer carries an error code");

   // A self request only closes a restart and always asks for credential transfer.
   a_self_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SELF |-> rsp_last && rsp_state_value == ST_CLI_CRED)
      else $error("self request is malformed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_state_value)
         && $stable(rsp_error_code) && $stable(rsp_last))
      else $error("stalled result transfer changed");

endmodule

bind handshake_connection_state_fsm_core hscs_checker u_hscs_checker (.*);

`default_nettype wire

// File: tb/handshake_connection_state_fsm_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the connection handshake state controller core.
// Drives peer messages and internal requests, predicts every result item and
// checks it; depends on hscs_pkg and handshake_connection_state_fsm_core.

module handshake_connection_state_fsm_core_test;
   import hscs_pkg::*;

   localparam logic       SRC_INSIDE    = 1'b1;
   localparam logic [1:0] SND_OTHER     = 2'd2;
   localparam logic [1:0] SND_SPARE     = 2'd3;
   localparam logic       SIDE_SERVER   = 1'b1;
   localparam int         HOLD_CYCLES   = 40;
   localparam int         QUIET_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 4;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   wire        csr_ready;
   logic       csr_connection_side = 1'b0;
   logic       req_valid = 1'b0;
   wire        req_stall;
   logic       req_source = 1'b0;
   logic       req_header_ok = 1'b0;
   logic       req_frame_ok = 1'b0;
   logic [3:0] req_requested_state = 4'd0;
   logic [1:0] req_sender = 2'd0;
   wire        rsp_valid;
   logic       rsp_stall = 1'b0;
   wire  [1:0] rsp_kind;
   wire  [2:0] rsp_state_value;
   wire  [2:0] rsp_error_code;
   wire        rsp_last;

   logic [2:0] link_local = ST_STARTED;
   logic [3:0] link_peer = 4'd0;
   logic       link_side = SIDE_CLIENT;
   item_type   pending_items[$];

   int         fail_count = 0;
   int         quiet_cycles = 0;
   int         idle_pct = 0;
   int         stall_pct = 0;
   int         walk_code = 0;
   logic       hold_request = 1'b0;
   int         hold_left = 0;

   handshake_connection_state_fsm_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_connection_side (csr_connection_side),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_source          (req_source),
      .req_header_ok       (req_header_ok),
      .req_frame_ok        (req_frame_ok),
      .req_requested_state (req_requested_state),
      .req_sender          (req_sender),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_state_value     (rsp_state_value),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void push_item(logic [1:0] kind, logic [2:0] st, logic [2:0] err);
      item_type it;
      it.kind        = kind;
      it.state_value = st;
      it.error_code  = err;
      it.last        = 1'b0;
      pending_items.push_back(it);
   endfunction

   function automatic void enter_state(logic [2:0] st);
      link_local = st;
      push_item(KIND_NOTIFY, st, ERR_NONE);
   endfunction

   function automatic void flag_illegal(logic bad);
      if (bad) push_item(KIND_ERROR, '0, ERR_ILLEGAL);
   endfunction

   function automatic void restart_link();
      if (link_local != ST_STARTED) begin
         link_local = ST_STARTED;
         push_item(KIND_NOTIFY, ST_STARTED, ERR_NONE);
         if (link_peer != 4'd0) push_item(KIND_SEND, ST_STARTED, ERR_NONE);
         push_item(KIND_SELF, ST_CLI_CRED, ERR_NONE);
      end else if (link_peer == 4'd0) begin
         enter_state(ST_CLI_CRED);
         push_item(KIND_SEND, ST_CLI_CRED, ERR_NONE);
      end
   endfunction

   function automatic void peer_message(logic [3:0] code);
      logic       client;
      logic [2:0] s;
      client    = (link_side == SIDE_CLIENT);
      s         = link_local;
      link_peer = code;
      if (code[3]) begin
         push_item(KIND_ERROR, '0, ERR_INVALID);
      end else begin
         case (code[2:0])
            ST_STARTED: restart_link();
            ST_CLI_CRED: begin
               if (s == ST_STARTED) enter_state(ST_CLI_CRED);
               else flag_illegal(s != ST_CLI_CRED);
            end
            ST_CLI_REG: begin
               if (client && s == ST_CLI_CRED) enter_state(ST_CLI_REG);
               else flag_illegal(client || s != ST_CLI_REG);
            end
            ST_CLI_TLS: begin
               if (client && (s == ST_CLI_CRED || s == ST_CLI_REG)) enter_state(ST_CLI_TLS);
               else flag_illegal(client || s != ST_CLI_TLS);
            end
            ST_SRV_CRED: begin
               if (client && s == ST_CLI_TLS) enter_state(ST_SRV_CRED);
               else flag_illegal(client || s != ST_SRV_CRED);
            end
            ST_SRV_TLS: begin
               if (!client && s == ST_SRV_CRED) enter_state(ST_SRV_TLS);
               else flag_illegal(client ? (s != ST_SRV_TLS) : 1'b1);
            end
            ST_SECURE: flag_illegal(s != ST_SECURE);
            default: enter_state(ST_END);
         endcase
      end
   endfunction

   function automatic void internal_request(logic [3:0] code, logic [1:0] snd);
      logic       by_cert;
      logic       ok;
      logic [2:0] s;
      s       = link_local;
      by_cert = (snd == SND_CERT);
      ok      = 1'b0;
      if (code == {1'b0, ST_STARTED}) begin
         restart_link();
      end else if (!code[3]) begin
         case (code[2:0])
            ST_CLI_CRED: ok = (s == ST_STARTED) && snd == SND_SELF;
            ST_CLI_REG:  ok = (s == ST_CLI_CRED) && by_cert;
            ST_CLI_TLS:  ok = (s == ST_CLI_CRED || s == ST_CLI_REG) && by_cert;
            ST_SRV_CRED: ok = (s == ST_CLI_TLS) && by_cert;
            ST_SRV_TLS:  ok = (s == ST_SRV_CRED) && by_cert;
            ST_END:      ok = 1'b1;
            default:     ok = 1'b0;
         endcase
      end
      if (ok) begin
         enter_state(code[2:0]);
         push_item(KIND_SEND, code[2:0], ERR_NONE);
      end
   endfunction

   function automatic void predict_event(logic src, logic hdr, logic frm,
                                         logic [3:0] code, logic [1:0] snd);
      int       prior_count;
      item_type tail;
      prior_count = pending_items.size();
      if (src == SRC_PEER) begin
         if (!hdr) push_item(KIND_ERROR, '0, ERR_HEADER);
         else if (!frm) push_item(KIND_ERROR, '0, ERR_FRAME);
         else peer_message(code);
      end else begin
         internal_request(code, snd);
      end
      if (pending_items.size() > prior_count) begin
         tail      = pending_items.pop_back();
         tail.last = 1'b1;
         pending_items.push_back(tail);
      end
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      item_type want;
      quiet_cycles++;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            link_side    = csr_connection_side;
            quiet_cycles = 0;
         end
         if (req_valid && !req_stall) begin
            predict_event(req_source, req_header_ok, req_frame_ok,
                          req_requested_state, req_sender);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (pending_items.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "actual kind %0d state %0d error %0d last %0d"},
                        $time, rsp_kind, rsp_state_value, rsp_error_code, rsp_last);
               fail_count++;
            end else begin
               want = pending_items.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("state_value", want.state_value, rsp_state_value);
               check_field("error_code", want.error_code, rsp_error_code);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
         hold_request <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic send_event(input logic src, input logic hdr, input logic frm,
                             input logic [3:0] code, input logic [1:0] snd);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid           <= 1'b1;
      req_source          <= src;
      req_header_ok       <= hdr;
      req_frame_ok        <= frm;
      req_requested_state <= code;
      req_sender          <= snd;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic peer_msg(input logic [3:0] code);
      send_event(SRC_PEER, 1'b1, 1'b1, code, 2'($urandom_range(3)));
   endtask

   task automatic inside_req(input logic [3:0] code, input logic [1:0] snd);
      send_event(SRC_INSIDE, 1'($urandom_range(1)), 1'($urandom_range(1)), code, snd);
   endtask

   task automatic send_random();
      logic [1:0] snd;
      if ($urandom_range(99) < 25) begin
         send_event(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    4'($urandom_range(15)), 2'($urandom_range(3)));
      end else begin
         if ($urandom_range(99) < 10) walk_code = ST_STARTED;
         else if ($urandom_range(99) < 5) walk_code = ST_END;
         snd = (walk_code == ST_CLI_CRED) ? SND_SELF : SND_CERT;
         if ($urandom_range(99) < 10) snd = 2'($urandom_range(3));
         if ($urandom_range(1) == 0) peer_msg(4'(walk_code));
         else inside_req(4'(walk_code), snd);
         walk_code = (walk_code + 1) % 8;
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input logic side);
      csr_valid           <= 1'b1;
      csr_connection_side <= side;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_client();
      settle_block();
      write_side(SIDE_CLIENT);
      idle_pct  = 0;
      stall_pct = 0;
      send_event(SRC_PEER, 1'b0, 1'b1, 4'd15, SND_SPARE);
      send_event(SRC_PEER, 1'b1, 1'b0, {1'b0, ST_STARTED}, SND_SELF);
      peer_msg(4'd15);
      peer_msg({1'b0, ST_STARTED});
      inside_req({1'b0, ST_CLI_REG}, SND_CERT);
      inside_req({1'b0, ST_CLI_TLS}, SND_CERT);
      inside_req({1'b0, ST_SRV_CRED}, SND_CERT);
      inside_req({1'b0, ST_SRV_TLS}, SND_SELF);
      inside_req({1'b0, ST_SRV_TLS}, SND_CERT);
      peer_msg({1'b0, ST_SRV_TLS});
      inside_req({1'b0, ST_SECURE}, SND_CERT);
      inside_req(4'd12, SND_CERT);
      inside_req({1'b0, ST_END}, SND_SPARE);
      peer_msg({1'b0, ST_SECURE});
      inside_req({1'b0, ST_STARTED}, SND_OTHER);
      inside_req({1'b0, ST_STARTED}, SND_SELF);
      inside_req({1'b0, ST_CLI_CRED}, SND_OTHER);
      inside_req({1'b0, ST_CLI_CRED}, SND_SELF);
      peer_msg({1'b0, ST_CLI_REG});
      peer_msg({1'b0, ST_CLI_TLS});
      peer_msg({1'b0, ST_SRV_CRED});
      peer_msg({1'b0, ST_CLI_CRED});
      peer_msg({1'b0, ST_END});
   endtask

   task automatic test_directed_server();
      settle_block();
      write_side(SIDE_SERVER);
      peer_msg({1'b0, ST_STARTED});
      peer_msg({1'b0, ST_CLI_CRED});
      inside_req({1'b0, ST_CLI_REG}, SND_CERT);
      peer_msg({1'b0, ST_CLI_REG});
      peer_msg({1'b0, ST_CLI_TLS});
      inside_req({1'b0, ST_CLI_TLS}, SND_CERT);
      inside_req({1'b0, ST_SRV_CRED}, SND_CERT);
      peer_msg({1'b0, ST_SRV_TLS});
      peer_msg({1'b0, ST_SRV_TLS});
   endtask

   task automatic test_random_phase(input logic side, input int idle, input int stall,
                                    input int count);
      settle_block();
      write_side(side);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_random();
   endtask

   task automatic test_backpressure();
      settle_block();
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request <= 1'b1;
      repeat (16) send_random();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_client();
      test_directed_server();
      test_random_phase(SIDE_CLIENT, 0, 0, 15);
      test_random_phase(SIDE_SERVER, 75, 0, 15);
      test_random_phase(SIDE_CLIENT, 0, 75, 15);
      test_random_phase(SIDE_SERVER, 25, 25, 15);
      test_backpressure();
      test_random_phase(SIDE_SERVER, 0, 0, 15);
      test_random_phase(SIDE_CLIENT, 75, 0, 15);
      test_random_phase(SIDE_SERVER, 0, 75, 15);
      test_random_phase(SIDE_CLIENT, 25, 25, 15);
      settle_block();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
